// ===== src/cld_pkg.sv =====
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types, constants and index helpers of the console line discipline.
// ----------------------------------------------------------------------------
package cld_pkg;

  // Store geometry; indices count modulo twice the depth so full and empty differ
  localparam int BUFFER_DEPTH = 128;
  localparam int IDX_MOD      = 2 * BUFFER_DEPTH;
  localparam int IDX_W        = $clog2(IDX_MOD);
  localparam int SLOT_W       = $clog2(BUFFER_DEPTH);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // Control characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_EOF     = 8'h04;
  localparam logic [7:0] CH_KILL    = 8'h15;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_THREADS = 8'h14;

  // Input opcodes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Echo kinds
  localparam logic [1:0] EK_NONE  = 2'd0;
  localparam logic [1:0] EK_BYTE  = 2'd1;
  localparam logic [1:0] EK_ERASE = 2'd2;

  // Read status codes
  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_DATA  = 2'd1;
  localparam logic [1:0] RS_EMPTY = 2'd2;
  localparam logic [1:0] RS_EOF   = 2'd3;

  // Configuration register indices
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRNL      = 2'd2;

  // Datapath actions issued by the controller
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CHAR,
    ACT_READ_EMPTY,
    ACT_READ_START,
    ACT_READ_POP,
    ACT_KILL_START,
    ACT_KILL_STEP,
    ACT_KILL_END
  } act_e;

  typedef struct packed {
    act_e act;
    logic finish;
  } cld_cmd_t;

  typedef struct packed {
    logic out_free;
    logic canonical;
    logic read_eq_commit;
    logic edit_eq_commit;
    logic kill_hit_nl;
    logic kill_last;
  } cld_sts_t;

  // a + 1 modulo IDX_MOD
  function automatic idx_t idx_inc(input idx_t a);
    return (a == IDX_W'(IDX_MOD - 1)) ? '0 : a + IDX_W'(1);
  endfunction

  // a - 1 modulo IDX_MOD
  function automatic idx_t idx_dec(input idx_t a);
    return (a == '0) ? IDX_W'(IDX_MOD - 1) : a - IDX_W'(1);
  endfunction

  // a - b modulo IDX_MOD
  function automatic idx_t idx_diff(input idx_t a, input idx_t b);
    logic [IDX_W:0] t;
    t = {1'b0, a} + (IDX_W+1)'(IDX_MOD) - {1'b0, b};
    if (t >= (IDX_W+1)'(IDX_MOD)) begin
      t = t - (IDX_W+1)'(IDX_MOD);
    end
    return t[IDX_W-1:0];
  endfunction

  // Store slot of an index
  function automatic slot_t slot_of(input idx_t a);
    idx_t s;
    s = (a >= IDX_W'(BUFFER_DEPTH)) ? a - IDX_W'(BUFFER_DEPTH) : a;
    return s[SLOT_W-1:0];
  endfunction

  // Saturate a count to eight bits
  function automatic logic [7:0] sat8(input idx_t a);
    logic [IDX_W+7:0] w;
    w = (IDX_W+8)'(a);
    return (w > (IDX_W+8)'(255)) ? 8'hFF : w[7:0];
  endfunction

endpackage

// ===== src/cld_ram.sv =====
// ----------------------------------------------------------------------------
// cld_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cld_ctrl.sv =====
// ----------------------------------------------------------------------------
// cld_ctrl
// Controller: accepts items and sequences reads and the kill-line walk.
// ----------------------------------------------------------------------------
module cld_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             opcode_i,
  input  logic [7:0]       rx_char_i,
  input  cld_pkg::cld_sts_t sts_i,
  output logic             in_stall_o,
  output cld_pkg::cld_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KILL = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  // Take a new item only when idle and the result register can be loaded
  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and command
  always_comb begin
    state_d      = state_q;
    cmd_o.act    = cld_pkg::ACT_NONE;
    cmd_o.finish = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == cld_pkg::OP_READ) begin
            if (sts_i.read_eq_commit) begin
              cmd_o.act    = cld_pkg::ACT_READ_EMPTY;
              cmd_o.finish = 1'b1;
            end else begin
              cmd_o.act = cld_pkg::ACT_READ_START;
              state_d   = ST_READ;
            end
          end else if (sts_i.canonical && (rx_char_i == cld_pkg::CH_KILL) &&
                       !sts_i.edit_eq_commit) begin
            cmd_o.act = cld_pkg::ACT_KILL_START;
            state_d   = ST_KILL;
          end else begin
            // includes a kill with nothing to erase: no change
            cmd_o.act    = cld_pkg::ACT_CHAR;
            cmd_o.finish = 1'b1;
          end
        end
      end
      ST_KILL: begin
        if (sts_i.kill_hit_nl) begin
          cmd_o.act    = cld_pkg::ACT_KILL_END;
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.act = cld_pkg::ACT_KILL_STEP;
          if (sts_i.kill_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        cmd_o.act    = cld_pkg::ACT_READ_POP;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/cld_dp.sv =====
// ----------------------------------------------------------------------------
// cld_dp
// Datapath: ring store, read/commit/edit indices, settings and result register.
// ----------------------------------------------------------------------------
module cld_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cld_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic                              cfg_wdata_i,
  input  logic [7:0]                        rx_char_i,
  input  logic                              first_of_read_i,
  input  cld_pkg::cld_cmd_t                 cmd_i,
  output cld_pkg::cld_sts_t                 sts_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [1:0]                        echo_kind_o,
  output logic [7:0]                        echo_byte_o,
  output logic [7:0]                        erase_count_o,
  output logic [1:0]                        read_status_o,
  output logic [7:0]                        read_byte_o,
  output logic                              line_end_o,
  output logic                              wake_o,
  output logic [7:0]                        ready_count_o
);

  cld_pkg::idx_t  read_q, read_d;
  cld_pkg::idx_t  commit_q, commit_d;
  cld_pkg::idx_t  edit_q, edit_d;
  cld_pkg::idx_t  kill_cnt_q, kill_cnt_d;
  cld_pkg::idx_t  fill;
  logic           canon_q, echo_q, crnl_q;
  logic           first_q, first_d;
  logic           space;
  logic [7:0]     ch_map;

  // Store port
  logic           ram_we;
  cld_pkg::slot_t ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;

  // Result of the current step
  logic [1:0]     ek, rs;
  logic [7:0]     eb, ec, rb;
  logic           le, wk;

  // Result register
  logic           out_valid_q;
  logic [1:0]     echo_kind_q, read_status_q;
  logic [7:0]     echo_byte_q, erase_count_q, read_byte_q, ready_count_q;
  logic           line_end_q, wake_q;

  cld_ram #(
    .WIDTH(8),
    .DEPTH(cld_pkg::BUFFER_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign fill   = cld_pkg::idx_diff(edit_q, read_q);
  assign space  = fill < cld_pkg::IDX_W'(cld_pkg::BUFFER_DEPTH);
  assign ch_map = (crnl_q && (rx_char_i == cld_pkg::CH_CR)) ? cld_pkg::CH_NL : rx_char_i;

  // Status towards the controller
  assign sts_o.out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.canonical      = canon_q;
  assign sts_o.read_eq_commit = (read_q == commit_q);
  assign sts_o.edit_eq_commit = (edit_q == commit_q);
  assign sts_o.kill_hit_nl    = (ram_rdata == cld_pkg::CH_NL);
  assign sts_o.kill_last      = (cld_pkg::idx_dec(edit_q) == commit_q);

  // Step logic
  always_comb begin
    read_d     = read_q;
    commit_d   = commit_q;
    edit_d     = edit_q;
    kill_cnt_d = kill_cnt_q;
    first_d    = first_q;
    ram_we     = 1'b0;
    ram_waddr  = cld_pkg::slot_of(edit_q);
    ram_wdata  = rx_char_i;
    ram_raddr  = cld_pkg::slot_of(read_q);
    ek         = cld_pkg::EK_NONE;
    eb         = 8'h00;
    ec         = 8'h00;
    rs         = cld_pkg::RS_NONE;
    rb         = 8'h00;
    le         = 1'b0;
    wk         = 1'b0;
    case (cmd_i.act)
      cld_pkg::ACT_CHAR: begin
        if (!canon_q) begin
          // raw: store, echo and commit at once
          if ((rx_char_i != cld_pkg::CH_NUL) && space) begin
            ram_we   = 1'b1;
            edit_d   = cld_pkg::idx_inc(edit_q);
            commit_d = cld_pkg::idx_inc(edit_q);
            wk       = 1'b1;
            if (echo_q) begin
              ek = cld_pkg::EK_BYTE;
              eb = rx_char_i;
            end
          end
        end else if (rx_char_i inside {cld_pkg::CH_THREADS, cld_pkg::CH_KILL}) begin
          // no change: thread list, or kill on an empty line
        end else if (rx_char_i inside {cld_pkg::CH_BS, cld_pkg::CH_DEL}) begin
          if (edit_q != commit_q) begin
            edit_d = cld_pkg::idx_dec(edit_q);
            if (echo_q) begin
              ek = cld_pkg::EK_ERASE;
              ec = 8'd1;
            end
          end
        end else if ((rx_char_i != cld_pkg::CH_NUL) && space) begin
          ram_we    = 1'b1;
          ram_wdata = ch_map;
          edit_d    = cld_pkg::idx_inc(edit_q);
          if (echo_q) begin
            ek = cld_pkg::EK_BYTE;
            eb = ch_map;
          end
          // line ends on newline, end of file or a full store
          if ((ch_map == cld_pkg::CH_NL) || (ch_map == cld_pkg::CH_EOF) ||
              (fill == cld_pkg::IDX_W'(cld_pkg::BUFFER_DEPTH - 1))) begin
            commit_d = cld_pkg::idx_inc(edit_q);
            wk       = 1'b1;
          end
        end
      end
      cld_pkg::ACT_READ_EMPTY: begin
        rs = cld_pkg::RS_EMPTY;
      end
      cld_pkg::ACT_READ_START: begin
        ram_raddr = cld_pkg::slot_of(read_q);
        first_d   = first_of_read_i;
      end
      cld_pkg::ACT_READ_POP: begin
        if (canon_q && (ram_rdata == cld_pkg::CH_EOF)) begin
          // end of file is consumed only as the first byte of a read
          if (first_q) begin
            read_d = cld_pkg::idx_inc(read_q);
          end
          rs = cld_pkg::RS_EOF;
        end else begin
          read_d = cld_pkg::idx_inc(read_q);
          rs     = cld_pkg::RS_DATA;
          rb     = ram_rdata;
          le     = canon_q && (ram_rdata == cld_pkg::CH_NL);
        end
      end
      cld_pkg::ACT_KILL_START: begin
        ram_raddr  = cld_pkg::slot_of(cld_pkg::idx_dec(edit_q));
        kill_cnt_d = '0;
      end
      cld_pkg::ACT_KILL_STEP: begin
        // drop one entry and fetch the one before it
        edit_d     = cld_pkg::idx_dec(edit_q);
        kill_cnt_d = kill_cnt_q + cld_pkg::IDX_W'(1);
        ram_raddr  = cld_pkg::slot_of(cld_pkg::idx_dec(cld_pkg::idx_dec(edit_q)));
      end
      default: begin
      end
    endcase
    // kill result once the walk ends
    if (((cmd_i.act == cld_pkg::ACT_KILL_STEP) || (cmd_i.act == cld_pkg::ACT_KILL_END)) &&
        (kill_cnt_d != '0) && echo_q) begin
      ek = cld_pkg::EK_ERASE;
      ec = cld_pkg::sat8(kill_cnt_d);
    end
  end

  // Settings, indices and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canon_q     <= 1'b1;
      echo_q      <= 1'b1;
      crnl_q      <= 1'b1;
      read_q      <= '0;
      commit_q    <= '0;
      edit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          cld_pkg::CFG_CANONICAL: canon_q <= cfg_wdata_i;
          cld_pkg::CFG_ECHO:      echo_q  <= cfg_wdata_i;
          cld_pkg::CFG_CRNL:      crnl_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      read_q      <= read_d;
      commit_q    <= commit_d;
      edit_q      <= edit_d;
      out_valid_q <= cmd_i.finish || (out_valid_q && out_stall_i);
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    kill_cnt_q <= kill_cnt_d;
    first_q    <= first_d;
    if (cmd_i.finish) begin
      echo_kind_q   <= ek;
      echo_byte_q   <= eb;
      erase_count_q <= ec;
      read_status_q <= rs;
      read_byte_q   <= rb;
      line_end_q    <= le;
      wake_q        <= wk;
      ready_count_q <= cld_pkg::sat8(cld_pkg::idx_diff(commit_d, read_d));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign echo_kind_o   = echo_kind_q;
  assign echo_byte_o   = echo_byte_q;
  assign erase_count_o = erase_count_q;
  assign read_status_o = read_status_q;
  assign read_byte_o   = read_byte_q;
  assign line_end_o    = line_end_q;
  assign wake_o        = wake_q;
  assign ready_count_o = ready_count_q;

`ifndef SYNTH
  // store never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= cld_pkg::IDX_W'(cld_pkg::BUFFER_DEPTH))
    else $error("edit index ran past the read index by more than the depth");

  // committed bytes lie within the stored bytes
  a_commit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cld_pkg::idx_diff(commit_q, read_q) <= fill)
    else $error("commit index beyond edit index");

  // a step only finishes when the result register can take it
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> sts_o.out_free)
    else $error("result register overwritten");

  // the kill walk never erases committed bytes
  a_kill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.act == cld_pkg::ACT_KILL_STEP) |-> (edit_q != commit_q))
    else $error("kill step at the commit point");
`endif

endmodule

// ===== src/console_line_discipline_top.sv =====
// ----------------------------------------------------------------------------
// console_line_discipline_top
// Canonical/raw terminal line discipline over a ring store of received bytes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_stall_o     | opcode, rx_char, first_of_read
//  out     | output    | out_valid_o / out_stall_i   | echo, erase, read and count fields
//  cfg     | input     | cfg_we_i (no wait)          | cfg_index_i, cfg_wdata_i
//
//  A received character or an empty read finishes in its accepting step; a read with data
//  takes a start and a pop step. A kill-line takes a start step, one step per erased
//  character (at most BUFFER_DEPTH - 1) back to the commit point, or to a newline and an
//  end step; the walk reads one store entry per cycle through the single RAM read port.
//  Reset sets the indices to zero and all settings to 1; the store is not cleared.
//  The input is stalled while an item is in work or a result waits to be taken.
// ----------------------------------------------------------------------------
module console_line_discipline_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cld_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [7:0]                    rx_char_i,
  input  logic                          first_of_read_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    echo_kind_o,
  output logic [7:0]                    echo_byte_o,
  output logic [7:0]                    erase_count_o,
  output logic [1:0]                    read_status_o,
  output logic [7:0]                    read_byte_o,
  output logic                          line_end_o,
  output logic                          wake_o,
  output logic [7:0]                    ready_count_o
);

  cld_pkg::cld_cmd_t cmd;
  cld_pkg::cld_sts_t sts;

  cld_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .opcode_i  (opcode_i),
    .rx_char_i (rx_char_i),
    .sts_i     (sts),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  cld_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_char_i      (rx_char_i),
    .first_of_read_i(first_of_read_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .echo_kind_o    (echo_kind_o),
    .echo_byte_o    (echo_byte_o),
    .erase_count_o  (erase_count_o),
    .read_status_o  (read_status_o),
    .read_byte_o    (read_byte_o),
    .line_end_o     (line_end_o),
    .wake_o         (wake_o),
    .ready_count_o  (ready_count_o)
  );

endmodule

// ===== tb/tb_console_line_discipline_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_line_discipline_top
// Self-checking bench for the console line discipline. Drives received
// characters and read requests through the valid/stall handshake and models
// the ring store, the three indices and the edit rules. Every result transfer
// is compared field by field with the oldest predicted result. Settings are
// changed only once the block has drained.
// ----------------------------------------------------------------------------
module tb_console_line_discipline_top;
  import cld_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 300;
  localparam int MAX_LINES     = 50;

  // One result transfer of the block
  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_byte;
    logic [7:0] erase_count;
    logic [1:0] read_status;
    logic [7:0] read_byte;
    logic       line_end;
    logic       wake;
    logic [7:0] ready_count;
  } line_result_t;

  // Line discipline state mirror and queue of results still to arrive
  class line_ledger;
    logic [7:0]   ring [BUFFER_DEPTH];
    idx_t         rd_ptr, cm_ptr, ed_ptr;
    logic         canon, echo_on, crnl_on;
    line_result_t pending_results [$];
    int           errors;
    int           seen;

    function new();
      rd_ptr  = '0;
      cm_ptr  = '0;
      ed_ptr  = '0;
      canon   = 1'b1;
      echo_on = 1'b1;
      crnl_on = 1'b1;
      errors  = 0;
      seen    = 0;
    endfunction

    function idx_t wrap(input int v);
      return idx_t'((v + IDX_MOD) % IDX_MOD);
    endfunction

    function int span(input idx_t hi, input idx_t lo);
      return (int'(hi) - int'(lo) + IDX_MOD) % IDX_MOD;
    endfunction

    function slot_t ring_slot(input idx_t a);
      return slot_t'(int'(a) % BUFFER_DEPTH);
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function int ready_bytes();
      return span(cm_ptr, rd_ptr);
    endfunction

    function void configure(input logic [CFG_IDX_W-1:0] idx, input logic val);
      case (idx)
        CFG_CANONICAL: canon   = val;
        CFG_ECHO:      echo_on = val;
        CFG_CRNL:      crnl_on = val;
        default: ;
      endcase
    endfunction

    // Advance the mirror by one accepted item and queue its result
    function void note_item(input logic op, input logic [7:0] ch, input logic first);
      line_result_t r;
      logic [7:0]   c;
      int           n;
      r = '0;
      c = ch;
      if (op == OP_RX) begin
        if (!canon) begin
          // raw: store, echo and commit every nonzero byte that fits
          if (c != CH_NUL && span(ed_ptr, rd_ptr) < BUFFER_DEPTH) begin
            if (echo_on) begin
              r.echo_kind = EK_BYTE;
              r.echo_byte = c;
            end
            ring[ring_slot(ed_ptr)] = c;
            ed_ptr = wrap(int'(ed_ptr) + 1);
            cm_ptr = ed_ptr;
            r.wake = 1'b1;
          end
        end else if (c == CH_THREADS) begin
          // thread listing is not modelled: no effect
        end else if (c == CH_KILL) begin
          n = 0;
          while (ed_ptr != cm_ptr && ring[ring_slot(wrap(int'(ed_ptr) - 1))] != CH_NL) begin
            ed_ptr = wrap(int'(ed_ptr) - 1);
            n++;
          end
          if (n != 0 && echo_on) begin
            r.echo_kind   = EK_ERASE;
            r.erase_count = (n > 255) ? 8'hFF : 8'(n);
          end
        end else if (c == CH_BS || c == CH_DEL) begin
          if (ed_ptr != cm_ptr) begin
            ed_ptr = wrap(int'(ed_ptr) - 1);
            if (echo_on) begin
              r.echo_kind   = EK_ERASE;
              r.erase_count = 8'd1;
            end
          end
        end else if (c != CH_NUL && span(ed_ptr, rd_ptr) < BUFFER_DEPTH) begin
          if (crnl_on && c == CH_CR) c = CH_NL;
          if (echo_on) begin
            r.echo_kind = EK_BYTE;
            r.echo_byte = c;
          end
          ring[ring_slot(ed_ptr)] = c;
          ed_ptr = wrap(int'(ed_ptr) + 1);
          // newline, end of file or a full ring commits the line
          if (c == CH_NL || c == CH_EOF || span(ed_ptr, rd_ptr) == BUFFER_DEPTH) begin
            cm_ptr = ed_ptr;
            r.wake = 1'b1;
          end
        end
      end else begin
        if (rd_ptr == cm_ptr) begin
          r.read_status = RS_EMPTY;
        end else begin
          c = ring[ring_slot(rd_ptr)];
          if (canon && c == CH_EOF) begin
            // end of file is consumed only at the start of a read
            if (first) rd_ptr = wrap(int'(rd_ptr) + 1);
            r.read_status = RS_EOF;
          end else begin
            rd_ptr = wrap(int'(rd_ptr) + 1);
            r.read_status = RS_DATA;
            r.read_byte   = c;
            r.line_end    = canon && (c == CH_NL);
          end
        end
      end
      n = span(cm_ptr, rd_ptr);
      r.ready_count = (n > 255) ? 8'hFF : 8'(n);
      pending_results.push_back(r);
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_LINES) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one result transfer with the oldest prediction
    task match_result(input line_result_t got);
      line_result_t want;
      seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", seen));
        return;
      end
      want = pending_results.pop_front();
      if (got.echo_kind !== want.echo_kind)
        report($sformatf("result %0d echo_kind %0d, want %0d", seen,
                         got.echo_kind, want.echo_kind));
      if (got.echo_byte !== want.echo_byte)
        report($sformatf("result %0d echo_byte %02h, want %02h", seen,
                         got.echo_byte, want.echo_byte));
      if (got.erase_count !== want.erase_count)
        report($sformatf("result %0d erase_count %0d, want %0d", seen,
                         got.erase_count, want.erase_count));
      if (got.read_status !== want.read_status)
        report($sformatf("result %0d read_status %0d, want %0d", seen,
                         got.read_status, want.read_status));
      if (got.read_byte !== want.read_byte)
        report($sformatf("result %0d read_byte %02h, want %02h", seen,
                         got.read_byte, want.read_byte));
      if (got.line_end !== want.line_end)
        report($sformatf("result %0d line_end %0b, want %0b", seen,
                         got.line_end, want.line_end));
      if (got.wake !== want.wake)
        report($sformatf("result %0d wake %0b, want %0b", seen, got.wake, want.wake));
      if (got.ready_count !== want.ready_count)
        report($sformatf("result %0d ready_count %0d, want %0d", seen,
                         got.ready_count, want.ready_count));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic                 cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [7:0]           rx_char_i;
  logic                 first_of_read_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           echo_kind_o;
  logic [7:0]           echo_byte_o;
  logic [7:0]           erase_count_o;
  logic [1:0]           read_status_o;
  logic [7:0]           read_byte_o;
  logic                 line_end_o;
  logic                 wake_o;
  logic [7:0]           ready_count_o;

  line_ledger   ledger = new();
  line_result_t got;
  logic         quiet;
  logic         hold_req;
  int           gap_pct;
  int           stall_pct;

  console_line_discipline_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .rx_char_i       (rx_char_i),
    .first_of_read_i (first_of_read_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .echo_kind_o     (echo_kind_o),
    .echo_byte_o     (echo_byte_o),
    .erase_count_o   (erase_count_o),
    .read_status_o   (read_status_o),
    .read_byte_o     (read_byte_o),
    .line_end_o      (line_end_o),
    .wake_o          (wake_o),
    .ready_count_o   (ready_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.echo_kind   = echo_kind_o;
      got.echo_byte   = echo_byte_o;
      got.erase_count = erase_count_o;
      got.read_status = read_status_o;
      got.read_byte   = read_byte_o;
      got.line_end    = line_end_o;
      got.wake        = wake_o;
      got.ready_count = ready_count_o;
      ledger.match_result(got);
    end
  end

  // Ordinary byte: printable or high half, never a control character
  function automatic logic [7:0] plain_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Offer one item and hold it until the transfer, then maybe idle a burst
  task automatic send_item(input logic op, input logic [7:0] ch, input logic first);
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    rx_char_i       <= ch;
    first_of_read_i <= first;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_item(op, ch, first);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (ledger.outstanding() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    ledger.configure(idx, val);
  endtask

  // Drain, then write every register including the unmapped index
  task automatic program_settings(input logic canon, input logic echo, input logic crnl);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write(CFG_CANONICAL, canon);
    cfg_write(CFG_ECHO, echo);
    cfg_write(CFG_CRNL, crnl);
    cfg_write(CFG_SPARE, 1'($urandom_range(0, 1)));
    cfg_we_i <= 1'b0;
  endtask

  // Mixed traffic: mostly line typing with edits and terminators, plus reads
  task automatic run_random(input int count, input int read_pct);
    int         s;
    logic [7:0] ch;
    repeat (count) begin
      if (!quiet && $urandom_range(0, 59) == 0) wait_for_results();
      if ($urandom_range(0, 99) < read_pct) begin
        send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        s = $urandom_range(0, 99);
        if (s < 62)      ch = plain_char();
        else if (s < 72) ch = $urandom_range(0, 1) ? CH_CR : CH_NL;
        else if (s < 78) ch = $urandom_range(0, 1) ? CH_BS : CH_DEL;
        else if (s < 81) ch = CH_KILL;
        else if (s < 85) ch = CH_EOF;
        else if (s < 87) ch = CH_THREADS;
        else if (s < 89) ch = CH_NUL;
        else             ch = 8'($urandom_range(0, 255));
        send_item(OP_RX, ch, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Main sequence
  initial begin
    int ph;
    in_valid_i      = 1'b0;
    opcode_i        = OP_RX;
    rx_char_i       = CH_NUL;
    first_of_read_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_CANONICAL;
    cfg_wdata_i     = 1'b0;
    rst_ni          = 1'b0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    gap_pct         = 20;
    stall_pct       = 20;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset settings first, then every edit rule and read case
    send_item(OP_READ, 8'h00, 1'b1);      // read with nothing committed
    send_item(OP_RX, CH_NUL, 1'b0);       // zero byte ignored
    send_item(OP_RX, 8'h61, 1'b0);
    send_item(OP_RX, 8'hFF, 1'b1);
    send_item(OP_RX, CH_BS, 1'b0);
    send_item(OP_RX, CH_DEL, 1'b0);
    send_item(OP_RX, CH_DEL, 1'b0);       // nothing left to erase
    send_item(OP_RX, CH_THREADS, 1'b0);
    send_item(OP_RX, 8'h78, 1'b0);
    send_item(OP_RX, 8'h79, 1'b0);
    send_item(OP_RX, CH_KILL, 1'b0);
    send_item(OP_RX, CH_KILL, 1'b0);      // kill on an empty line
    send_item(OP_RX, 8'h68, 1'b0);
    send_item(OP_RX, CH_CR, 1'b0);        // mapped to newline, commits
    send_item(OP_RX, CH_EOF, 1'b0);       // end of file commits too
    send_item(OP_READ, 8'h00, 1'b1);
    send_item(OP_READ, 8'hFF, 1'b0);      // newline, line end flagged
    send_item(OP_READ, 8'h00, 1'b0);      // end of file mid-read stays put
    send_item(OP_READ, 8'h00, 1'b1);      // end of file at read start is consumed
    send_item(OP_READ, 8'h00, 1'b1);
    program_settings(1'b1, 1'b1, 1'b0);
    send_item(OP_RX, CH_CR, 1'b0);        // carriage return kept as is
    send_item(OP_RX, CH_NL, 1'b0);
    send_item(OP_READ, 8'h00, 1'b1);
    send_item(OP_READ, 8'h00, 1'b0);

    // Random phases over a spread of settings
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: program_settings(1'b0, 1'b0, 1'b0);
        1: program_settings(1'b1, 1'b1, 1'b1);
        2: program_settings(1'b0, 1'b1, 1'b0);
        3: program_settings(1'b1, 1'b0, 1'b1);
        default: program_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
      endcase
      gap_pct   = (ph % 3 == 2) ? 0 : $urandom_range(10, 40);
      stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(10, 40);
      run_random(60, $urandom_range(15, 55));

      if (ph == 3) begin
        // Longest kill walk, then fill the ring under a long receiver hold-off
        program_settings(1'b1, 1'b1, 1'($urandom_range(0, 1)));
        send_item(OP_RX, CH_KILL, 1'b0);
        while (ledger.ready_bytes() != 0) send_item(OP_READ, 8'h00, 1'b1);
        repeat (BUFFER_DEPTH - 1) send_item(OP_RX, plain_char(), 1'b0);
        send_item(OP_RX, CH_KILL, 1'b0);
        hold_req = 1'b1;
        repeat (BUFFER_DEPTH + 2) send_item(OP_RX, plain_char(), 1'b0);
        send_item(OP_RX, CH_BS, 1'b0);    // committed line cannot be erased
        repeat (BUFFER_DEPTH + 1) send_item(OP_READ, 8'h00, 1'b1);
      end
    end

    // Closing stretch with no idling on either side
    quiet = 1'b1;
    program_settings(1'b1, 1'b1, 1'b1);
    run_random(120, 35);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (ledger.outstanding() != 0) ledger.report("results still pending at end of run");
    if (ledger.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
